### rtl/core/lis_pkg.sv
// lis_pkg: shared types and constants for the linear inequality interval solver
`default_nettype none

package lis_pkg;

    // width of the epsilon register and of the reported bounds
    localparam int EPS_BITS    = 31;
    localparam int OUT_BITS    = 31;
    localparam logic [EPS_BITS-1:0] EPS_RESET = 31'd1;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // kind of row as seen by the front
    typedef enum logic
    {
        ROW_BOUNDED = 1'b0,
        ROW_ZERO    = 1'b1
    } row_kind_t;

    // back sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'd0,
        ST_DIV    = 2'd1,
        ST_UPDATE = 2'd2,
        ST_EMIT   = 2'd3
    } lis_state_t;

    // control part of one queued item
    typedef struct packed
    {
        row_kind_t kind;
        logic      zero_fail;
        logic      lo_neg;
        logic      hi_neg;
        logic      last;
    } lis_ctl_t;

endpackage

`default_nettype wire

### rtl/core/lis_front.sv
// lis_front: epsilon register, row classification and operand preparation
`default_nettype none

module lis_front
    import lis_pkg::*;
#(
    parameter int W = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [W-1:0] a_value,
    input  wire logic signed [W-1:0] b_value,
    input  wire logic signed [W-1:0] c_value,
    input  wire logic                last_row,
    input  wire logic                cfg_wr_en,
    input  wire logic [EPS_BITS-1:0] cfg_wr_data,
    input  wire logic                q_full,
    output logic                     q_push,
    output lis_ctl_t                 q_ctl,
    output logic [W-1:0]             lo_mag,
    output logic [W-1:0]             hi_mag,
    output logic [W-1:0]             den_mag
);

    localparam int CW = ((W > EPS_BITS) ? W : EPS_BITS) + 1;

    logic [EPS_BITS-1:0] epsilon_reg;
    logic [EPS_BITS-1:0] epsilon_next;
    logic                b_neg;
    logic                b_zero;
    logic [W-1:0]        lo_src;
    logic [W-1:0]        hi_src;
    logic signed [CW-1:0] a_ext;
    logic signed [CW-1:0] c_ext;
    logic signed [CW-1:0] eps_ext;

    // epsilon register
    always_comb
    begin
        epsilon_next = cfg_wr_en ? cfg_wr_data : epsilon_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= EPS_RESET;
        end
        else
        begin
            epsilon_reg <= epsilon_next;
        end
    end

    // handshake toward the queue
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // pick numerators by sign of the coefficient
    assign b_neg  = b_value[W-1];
    assign b_zero = (b_value == '0);
    assign lo_src = b_neg ? c_value : a_value;
    assign hi_src = b_neg ? a_value : c_value;

    // magnitudes, most negative word maps onto its unsigned pattern
    assign lo_mag  = lo_src[W-1]  ? (~lo_src + W'(1))  : lo_src;
    assign hi_mag  = hi_src[W-1]  ? (~hi_src + W'(1))  : hi_src;
    assign den_mag = b_value[W-1] ? (~b_value + W'(1)) : b_value;

    // tolerance check for zero-coefficient rows
    assign a_ext   = CW'(a_value);
    assign c_ext   = CW'(c_value);
    assign eps_ext = $signed(CW'(epsilon_reg));

    always_comb
    begin
        q_ctl.kind      = b_zero ? ROW_ZERO : ROW_BOUNDED;
        q_ctl.zero_fail = (a_ext > eps_ext) || (c_ext < -eps_ext);
        q_ctl.lo_neg    = lo_src[W-1] ^ b_neg;
        q_ctl.hi_neg    = hi_src[W-1] ^ b_neg;
        q_ctl.last      = last_row;
    end

endmodule

`default_nettype wire

### rtl/core/lis_queue.sv
// lis_queue: short item queue between the front and the back
`default_nettype none

module lis_queue
    import lis_pkg::*;
#(
    parameter int DATA_W = 96
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lis_ctl_t          push_ctl,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic                   full,
    output logic                   valid,
    output lis_ctl_t               head_ctl,
    output logic [DATA_W-1:0]      head_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lis_ctl_t          ctl_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] data_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign head_ctl  = ctl_mem[rd_ptr_reg];
    assign head_data = data_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg]  <= push_ctl;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && (count_reg == '0)))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### rtl/core/lis_divider.sv
// lis_divider: serial radix-2 saturating fixed-point divider, one quotient bit per cycle
`default_nettype none

module lis_divider
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] num_mag,
    input  wire logic [W-1:0] den_mag,
    input  wire logic         neg,
    output logic              done,
    output logic signed [W-1:0] quot
);

    localparam int STEPS = W + F;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [STEPS-1:0] dvd_reg;
    logic [STEPS-1:0] dvd_next;
    logic [W-1:0]     den_reg;
    logic [W-1:0]     den_next;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W:0]       q_reg;
    logic [W:0]       q_next;
    logic             over_reg;
    logic             over_next;
    logic             neg_reg;
    logic             neg_next;
    logic             done_reg;
    logic             done_next;
    logic [W-1:0]     quot_reg;
    logic [W-1:0]     quot_next;

    logic [W:0]       trial;
    logic             fits;
    logic [W:0]       lim;
    logic [W:0]       q_shift;
    logic [W-1:0]     mag;

    // one restoring step
    assign trial   = {rem_reg, dvd_reg[STEPS-1]};
    assign fits    = (trial >= {1'b0, den_reg});
    assign lim     = neg_reg ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - (W+1)'(1));
    assign q_shift = {q_reg[W-1:0], fits};
    assign mag     = over_reg ? lim[W-1:0] : q_reg[W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        over_next = over_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            dvd_next  = STEPS'(num_mag) << F;
            den_next  = den_mag;
            rem_next  = '0;
            q_next    = '0;
            over_next = 1'b0;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                dvd_next = dvd_reg << 1;
                rem_next = fits ? W'(trial - {1'b0, den_reg}) : trial[W-1:0];
                if (!over_reg)
                begin
                    q_next = q_shift;
                    if (q_shift > lim)
                    begin
                        over_next = 1'b1;
                    end
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            else
            begin
                // apply sign to the saturated magnitude
                quot_next = neg_reg ? (~mag + W'(1)) : mag;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        over_reg <= over_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = $signed(quot_reg);

endmodule

`default_nettype wire

### rtl/core/lis_back.sv
// lis_back: interval update sequencer with two dividers and the result register
`default_nettype none

module lis_back
    import lis_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire lis_ctl_t             q_ctl,
    input  wire logic [W-1:0]         lo_mag,
    input  wire logic [W-1:0]         hi_mag,
    input  wire logic [W-1:0]         den_mag,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      solution_exists,
    output logic [OUT_BITS-1:0]       min_delta,
    output logic [OUT_BITS-1:0]       max_delta,
    output logic                      max_unbounded
);

    localparam int OW = (W > OUT_BITS) ? W : OUT_BITS;

    lis_state_t          state_reg;
    lis_state_t          state_next;
    lis_ctl_t            ctl_reg;
    lis_ctl_t            ctl_next;
    logic signed [W-1:0] lower_bound_reg;
    logic signed [W-1:0] lower_bound_next;
    logic signed [W-1:0] upper_bound_reg;
    logic signed [W-1:0] upper_bound_next;
    logic                upper_inf_reg;
    logic                upper_inf_next;
    logic                infeasible_reg;
    logic                infeasible_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                sol_reg;
    logic                sol_next;
    logic [OUT_BITS-1:0] min_reg;
    logic [OUT_BITS-1:0] min_next;
    logic [OUT_BITS-1:0] max_reg;
    logic [OUT_BITS-1:0] max_next;
    logic                unb_reg;
    logic                unb_next;

    logic                div_start;
    logic                lo_done;
    logic                hi_done;
    logic signed [W-1:0] lo_quot;
    logic signed [W-1:0] hi_quot;
    logic                load;

    logic signed [W-1:0] lower_upd;
    logic signed [W-1:0] upper_upd;
    logic                upper_inf_upd;
    logic                infeasible_upd;
    logic [OW-1:0]       lower_ext;
    logic [OW-1:0]       upper_ext;

    // lower and upper quotient units run side by side
    lis_divider #(.W(W), .F(F)) u_div_lo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (lo_mag),
        .den_mag (den_mag),
        .neg     (q_ctl.lo_neg),
        .done    (lo_done),
        .quot    (lo_quot)
    );

    lis_divider #(.W(W), .F(F)) u_div_hi
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (hi_mag),
        .den_mag (den_mag),
        .neg     (q_ctl.hi_neg),
        .done    (hi_done),
        .quot    (hi_quot)
    );

    // interval tightening and feasibility test for the current row
    always_comb
    begin
        lower_upd      = lower_bound_reg;
        upper_upd      = upper_bound_reg;
        upper_inf_upd  = upper_inf_reg;
        infeasible_upd = infeasible_reg;
        if (ctl_reg.kind == ROW_BOUNDED)
        begin
            if (lo_quot > lower_bound_reg)
            begin
                lower_upd = lo_quot;
            end
            if (upper_inf_reg || (hi_quot < upper_bound_reg))
            begin
                upper_upd     = hi_quot;
                upper_inf_upd = 1'b0;
            end
        end
        else if (ctl_reg.zero_fail)
        begin
            infeasible_upd = 1'b1;
        end
        if (!upper_inf_upd && (lower_upd > upper_upd))
        begin
            infeasible_upd = 1'b1;
        end
    end

    // bounds extended to the larger of the word width and the reported width
    assign lower_ext = OW'(lower_bound_reg);
    assign upper_ext = OW'(upper_bound_reg);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        ctl_next         = ctl_reg;
        lower_bound_next = lower_bound_reg;
        upper_bound_next = upper_bound_reg;
        upper_inf_next   = upper_inf_reg;
        infeasible_next  = infeasible_reg;
        q_pop            = 1'b0;
        div_start        = 1'b0;
        load             = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    ctl_next = q_ctl;
                    if (!infeasible_reg && (q_ctl.kind == ROW_BOUNDED))
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_DIV:
            begin
                if (lo_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!infeasible_reg)
                begin
                    lower_bound_next = lower_upd;
                    upper_bound_next = upper_upd;
                    upper_inf_next   = upper_inf_upd;
                    infeasible_next  = infeasible_upd;
                end
                state_next = ctl_reg.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load             = 1'b1;
                    lower_bound_next = '0;
                    upper_bound_next = '0;
                    upper_inf_next   = 1'b1;
                    infeasible_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
        sol_next       = sol_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        unb_next       = unb_reg;
        if (load)
        begin
            sol_next = !infeasible_reg;
            min_next = infeasible_reg ? '0 : lower_ext[OUT_BITS-1:0];
            max_next = (infeasible_reg || upper_inf_reg) ? '0 : upper_ext[OUT_BITS-1:0];
            unb_next = !infeasible_reg && upper_inf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lower_bound_reg <= '0;
            upper_bound_reg <= '0;
            upper_inf_reg   <= 1'b1;
            infeasible_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lower_bound_reg <= lower_bound_next;
            upper_bound_reg <= upper_bound_next;
            upper_inf_reg   <= upper_inf_next;
            infeasible_reg  <= infeasible_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // item control and result payload
    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_next;
        sol_reg <= sol_next;
        min_reg <= min_next;
        max_reg <= max_next;
        unb_reg <= unb_next;
    end

    assign out_valid       = out_valid_reg;
    assign solution_exists = sol_reg;
    assign min_delta       = min_reg;
    assign max_delta       = max_reg;
    assign max_unbounded   = unb_reg;

`ifndef SYNTHESIS
    a_dividers_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lo_done == hi_done)
        else $error("quotient units out of step");

    a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV))
        else $error("divider started outside division state");

    a_interval_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && !infeasible_reg && !upper_inf_reg)
            |-> (lower_bound_reg <= upper_bound_reg))
        else $error("feasible set with empty interval");
`endif

endmodule

`default_nettype wire

### rtl/core/linear_inequality_interval_solver_core.sv
// linear_inequality_interval_solver_core: top level of the feasibility interval solver
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------------
//   input    | in        | in_valid/in_stall  | a_value, b_value, c_value, last_row
//   result   | out       | out_valid/out_stall| solution_exists, min_delta, max_delta,
//            |           |                    | max_unbounded
//   config   | in        | cfg_wr_en          | cfg_wr_data (epsilon)
//
// A bounded row (b nonzero) passes through the two serial dividers in the back, which
// produce one quotient bit per cycle.
// A zero-coefficient row, or any row of a set already infeasible, skips the dividers.
// A last row then passes the emit state, which loads the result register unless a held result is stalled.
// The two-entry queue takes items until full while the back divides or a result stalls.
// Reset clears the interval, the queue and the result valid; epsilon resets to 1.
`default_nettype none

module linear_inequality_interval_solver_core
    import lis_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [WORD_BITS-1:0] a_value,
    input  wire logic signed [WORD_BITS-1:0] b_value,
    input  wire logic signed [WORD_BITS-1:0] c_value,
    input  wire logic                        last_row,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             solution_exists,
    output logic [OUT_BITS-1:0]              min_delta,
    output logic [OUT_BITS-1:0]              max_delta,
    output logic                             max_unbounded,
    input  wire logic                        cfg_wr_en,
    input  wire logic [EPS_BITS-1:0]         cfg_wr_data
);

    localparam int DATA_W = 3 * WORD_BITS;

    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_valid;
    lis_ctl_t             push_ctl;
    lis_ctl_t             head_ctl;
    logic [WORD_BITS-1:0] f_lo_mag;
    logic [WORD_BITS-1:0] f_hi_mag;
    logic [WORD_BITS-1:0] f_den_mag;
    logic [DATA_W-1:0]    head_data;

    // classification side
    lis_front #(.W(WORD_BITS)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_value     (a_value),
        .b_value     (b_value),
        .c_value     (c_value),
        .last_row    (last_row),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_ctl       (push_ctl),
        .lo_mag      (f_lo_mag),
        .hi_mag      (f_hi_mag),
        .den_mag     (f_den_mag)
    );

    // item queue
    lis_queue #(.DATA_W(DATA_W)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_ctl  (push_ctl),
        .push_data ({f_lo_mag, f_hi_mag, f_den_mag}),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head_ctl  (head_ctl),
        .head_data (head_data)
    );

    // execution side
    lis_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_ctl           (head_ctl),
        .lo_mag          (head_data[3*WORD_BITS-1:2*WORD_BITS]),
        .hi_mag          (head_data[2*WORD_BITS-1:WORD_BITS]),
        .den_mag         (head_data[WORD_BITS-1:0]),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .solution_exists (solution_exists),
        .min_delta       (min_delta),
        .max_delta       (max_delta),
        .max_unbounded   (max_unbounded)
    );

endmodule

`default_nettype wire
